[design/fqkr_pkg.sv]
`default_nettype none
package fqkr_pkg;
  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_DEL_NAME = 2'd2,
    ACT_DEL_PID  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] name;
    logic [7:0]  prio;
    logic [21:0] pid;
    logic [19:0] run;
  } rec_t;

  localparam int REC_W = 114;
endpackage
`default_nettype wire

[design/fifo_queue_with_keyed_removal_core.sv]
// channel | dir | tdata fields (low bit up)                          | tuser
// in_     | in  | action[1:0] name[65:2] prio[73:66] pid[95:74] run[115:96] | -
// out_    | out | status[1:0] name[65:2] prio[74:66] pid[97:75] run[118:98] | -
// Push: write in S_SHIFT_WR, then S_OUT; when the queue is full, straight to S_OUT.
// Pop/delete: S_SCAN and S_CHECK compare each entry; S_SHIFT_RD and S_SHIFT_WR
// move each later entry up, then S_OUT closes; via one read and one write port.
// Reset clears the control state and occupancy; record memory holds no reset value.
// A result waits in the output register; the next item is taken once it has gone.
`default_nettype none
module fifo_queue_with_keyed_removal_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [119:0] in_tdata,   // action, key_name, priority, pid, runtime
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [119:0]      out_tdata   // status, name, priority, pid, runtime
);
  import fqkr_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rec_t mem [QUEUE_DEPTH];
  rec_t rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we;
  rec_t          wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt, idx_r, idx_nxt;
  action_t act_r, act_nxt;
  rec_t key_r, key_nxt, res_r, res_nxt;
  status_t st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r <= idx_nxt;
    act_r <= act_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    st_r  <= st_nxt;
  end

  assign hit = (act_r == ACT_POP) ||
               ((act_r == ACT_DEL_NAME) && (rd_q.name == key_r.name)) ||
               ((act_r == ACT_DEL_PID) && (rd_q.pid == key_r.pid));

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    act_nxt   = act_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    ov_nxt    = ov_r;
    in_tready = 1'b0;
    we        = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_data   = key_r;
    rd_addr   = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_tready = !ov_r;
        if (in_tvalid && !ov_r) begin
          act_nxt = action_t'(in_tdata[1:0]);
          key_nxt = '{name: in_tdata[65:2], prio: in_tdata[73:66],
                      pid: in_tdata[95:74], run: in_tdata[115:96]};
          idx_nxt = '0;
          if (action_t'(in_tdata[1:0]) == ACT_PUSH) begin
            state_nxt = S_OUT;
            if (occ_r == CW'(QUEUE_DEPTH)) begin
              st_nxt = ST_FULL;
            end else begin
              st_nxt  = ST_OK;
              idx_nxt = occ_r;
              state_nxt = S_SHIFT_WR;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r >= occ_r) begin
          st_nxt    = ST_NONE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          res_nxt   = rd_q;
          st_nxt    = ST_OK;
          state_nxt = S_SHIFT_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SHIFT_RD: begin
        if (idx_r + 1'b1 >= occ_r) begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = S_OUT;
        end else begin
          rd_addr   = AW'(idx_r + 1'b1);
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        if (act_r == ACT_PUSH) begin
          occ_nxt   = occ_r + 1'b1;
          state_nxt = S_OUT;
        end else begin
          wr_data   = rd_q;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SHIFT_RD;
        end
      end
      S_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  logic none;
  assign none = (st_r != ST_OK) || (act_r == ACT_PUSH);
  assign out_tvalid = ov_r;
  assign out_tdata = {1'b0,
                      none ? 21'h1FFFFF : {1'b0, res_r.run},
                      none ? 23'h7FFFFF : {1'b0, res_r.pid},
                      none ? 9'h1FF : {1'b0, res_r.prio},
                      none ? 64'd0 : res_r.name,
                      st_r};

  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(QUEUE_DEPTH)) else $error("occupancy overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_WR && act_r == ACT_PUSH) |-> (occ_r < CW'(QUEUE_DEPTH)))
    else $error("push into full queue");
endmodule
`default_nettype wire
